>>> hdl/assert_macros.svh
// assertion macros used by the port property checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every clock edge, reset included
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/sle_pkg.sv
package sle_pkg;

    // line buffer geometry
    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    // received byte codes
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_CTRL_C   = 8'h03;
    localparam logic [7:0] BYTE_CTRL_U   = 8'h15;
    localparam logic [7:0] BYTE_BS       = 8'h08;
    localparam logic [7:0] BYTE_DEL      = 8'h7F;
    localparam logic [7:0] BYTE_PRINT_LO = 8'h19;

    // command codes
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_CHAR    = 3'd1,
        ACT_ERASE   = 3'd2,
        ACT_BELL    = 3'd3,
        ACT_NEWLINE = 3'd4
    } echo_action_t;

    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_DONE   = 2'd1,
        ST_CANCEL = 2'd2
    } line_status_t;

    // result of the edit step, read byte still pending in the line store
    typedef struct packed {
        echo_action_t act;
        logic [7:0]   echo_char;
        logic [6:0]   erase_count;
        line_status_t status;
        logic [6:0]   line_length;
        logic         rd_hit;
    } result_t;

    // line store access request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // count to 7-bit output field, truncating or extending
    function automatic logic [6:0] to_len7(input logic [CNT_W-1:0] c);
        logic [CNT_W+6:0] t;
        t = {7'd0, c};
        return t[6:0];
    endfunction

    // read position inside the completed line
    function automatic logic idx_in_line(input logic [5:0] idx,
                                         input logic [CNT_W-1:0] len);
        logic [CNT_W+5:0] a;
        logic [CNT_W+5:0] b;
        a = {CNT_W'(0), idx};
        b = {6'd0, len};
        return a < b;
    endfunction

    // read position to store address
    function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [5:0] idx);
        logic [ADDR_W+5:0] t;
        t = {ADDR_W'(0), idx};
        return t[ADDR_W-1:0];
    endfunction

endpackage

>>> hdl/sle_line_ram.sv
module sle_line_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sle_edit_ctrl.sv
module sle_edit_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              echo_en,
    input  logic              cmd,
    input  logic [7:0]        rx_byte,
    input  logic [5:0]        read_index,
    output sle_pkg::result_t  res,
    output sle_pkg::mem_req_t mem_req
);

    logic [sle_pkg::CNT_W-1:0] char_count_reg;
    logic [sle_pkg::CNT_W-1:0] char_count_next;
    logic [sle_pkg::CNT_W-1:0] completed_length_reg;
    logic [sle_pkg::CNT_W-1:0] completed_length_next;
    logic                      is_eol;
    logic                      is_print;
    logic                      has_room;

    // line counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg       <= '0;
            completed_length_reg <= '0;
        end
        else
        begin
            char_count_reg       <= char_count_next;
            completed_length_reg <= completed_length_next;
        end
    end

    // byte classes
    assign is_eol   = (rx_byte == sle_pkg::BYTE_CR) || (rx_byte == sle_pkg::BYTE_LF);
    assign is_print = (rx_byte > sle_pkg::BYTE_PRINT_LO) && (rx_byte < sle_pkg::BYTE_DEL);
    assign has_room = char_count_reg < sle_pkg::CNT_W'(sle_pkg::LINE_DEPTH);

    // edit step
    always_comb
    begin
        char_count_next       = char_count_reg;
        completed_length_next = completed_length_reg;
        res                   = '0;
        res.act               = sle_pkg::ACT_NONE;
        res.status            = sle_pkg::ST_BUSY;
        mem_req               = '0;
        mem_req.waddr         = char_count_reg[sle_pkg::ADDR_W-1:0];
        mem_req.wdata         = rx_byte;
        mem_req.raddr         = sle_pkg::idx_to_addr(read_index);

        if (cmd == sle_pkg::CMD_READ)
        begin
            // read a byte of the completed line
            res.rd_hit = sle_pkg::idx_in_line(read_index, completed_length_reg);
            mem_req.re = accept;
        end
        else if (is_eol)
        begin
            // line complete
            completed_length_next = char_count_reg;
            char_count_next       = '0;
            res.act               = echo_en ? sle_pkg::ACT_NEWLINE : sle_pkg::ACT_NONE;
            res.status            = sle_pkg::ST_DONE;
            res.line_length       = sle_pkg::to_len7(char_count_reg);
        end
        else
        begin
            // any other byte starts a new line
            completed_length_next = '0;
            case (rx_byte)
                sle_pkg::BYTE_CTRL_C:
                begin
                    char_count_next = '0;
                    res.status      = sle_pkg::ST_CANCEL;
                end
                sle_pkg::BYTE_CTRL_U:
                begin
                    char_count_next = '0;
                    if (echo_en && (char_count_reg != '0))
                    begin
                        res.act         = sle_pkg::ACT_ERASE;
                        res.erase_count = sle_pkg::to_len7(char_count_reg);
                    end
                end
                sle_pkg::BYTE_BS, sle_pkg::BYTE_DEL:
                begin
                    if (char_count_reg != '0)
                    begin
                        char_count_next = char_count_reg - 1'b1;
                        if (echo_en)
                        begin
                            res.act         = sle_pkg::ACT_ERASE;
                            res.erase_count = 7'd1;
                        end
                    end
                end
                default:
                begin
                    if (is_print && has_room)
                    begin
                        mem_req.we      = accept;
                        char_count_next = char_count_reg + 1'b1;
                        if (echo_en)
                        begin
                            res.act       = sle_pkg::ACT_CHAR;
                            res.echo_char = rx_byte;
                        end
                    end
                    else
                    begin
                        res.act = sle_pkg::ACT_BELL;
                    end
                end
            endcase
        end

        // state only moves on an accepted item
        if (!accept)
        begin
            char_count_next       = char_count_reg;
            completed_length_next = completed_length_reg;
        end
    end

endmodule

>>> hdl/serial_line_editor.sv
// an accepted item's result passes the stage 1 register, then the output register
// throughput: one item per cycle while in_stall is low; the line store has one write and one read port
// an item is still taken while one finished result waits at a stalled output
// reset clears the line counters, the pipeline valids and echo_enable (silent)
// the line store is not cleared; only entries of the completed line are read
module serial_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] rx_byte,
    input  logic [5:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] echo_action,
    output logic [7:0] echo_char,
    output logic [6:0] erase_count,
    output logic [1:0] line_status,
    output logic [6:0] line_length,
    output logic [7:0] read_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic              accept;
    logic              p1_adv;
    logic              out_take;
    logic              echo_reg;
    logic              p1_valid_reg;
    logic              p1_valid_next;
    logic              o_valid_reg;
    logic              o_valid_next;
    sle_pkg::result_t  edit_res;
    sle_pkg::mem_req_t mem_req;
    sle_pkg::result_t  p1_res_reg;
    logic [7:0]        ram_rdata;
    logic [2:0]        act_reg;
    logic [7:0]        echo_char_reg;
    logic [6:0]        erase_count_reg;
    logic [1:0]        status_reg;
    logic [6:0]        line_length_reg;
    logic [7:0]        read_byte_reg;

    // handshakes
    assign out_take  = o_valid_reg && !out_stall;
    assign p1_adv    = p1_valid_reg && (!o_valid_reg || !out_stall);
    assign in_stall  = p1_valid_reg && o_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // echo enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            echo_reg <= cfg_data;
        end
    end

    sle_edit_ctrl u_edit (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .echo_en    (echo_reg),
        .cmd        (cmd),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .res        (edit_res),
        .mem_req    (mem_req)
    );

    sle_line_ram #(
        .DEPTH (sle_pkg::LINE_DEPTH),
        .WIDTH (8),
        .AW    (sle_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    // pipeline valids
    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (accept)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_adv)
        begin
            p1_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (p1_adv)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // stage 1 payload, waits for the store read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_res_reg <= edit_res;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (p1_adv)
        begin
            act_reg         <= p1_res_reg.act;
            echo_char_reg   <= p1_res_reg.echo_char;
            erase_count_reg <= p1_res_reg.erase_count;
            status_reg      <= p1_res_reg.status;
            line_length_reg <= p1_res_reg.line_length;
            read_byte_reg   <= p1_res_reg.rd_hit ? ram_rdata : 8'd0;
        end
    end

    assign out_valid   = o_valid_reg;
    assign echo_action = act_reg;
    assign echo_char   = echo_char_reg;
    assign erase_count = erase_count_reg;
    assign line_status = status_reg;
    assign line_length = line_length_reg;
    assign read_byte   = read_byte_reg;

endmodule

>>> hdl/sle_checker.sv
`include "assert_macros.svh"

module sle_port_props (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] echo_action,
    input logic [7:0] echo_char,
    input logic [6:0] erase_count,
    input logic [1:0] line_status,
    input logic [6:0] line_length
);

    // a stalled result stays offered
    `SLE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

    // echo char only travels with a char echo
    `SLE_ASSERT(a_char_only, out_valid && (echo_action != sle_pkg::ACT_CHAR) |-> echo_char == 8'd0, "stray echo char")

    // erase count only travels with an erase
    `SLE_ASSERT(a_erase_only, out_valid && (echo_action != sle_pkg::ACT_ERASE) |-> erase_count == 7'd0, "stray erase count")

    // length only reported on a completed line
    `SLE_ASSERT(a_len_done, out_valid && (line_status != sle_pkg::ST_DONE) |-> line_length == 7'd0, "length without completed line")

    // no result offered during reset
    `SLE_ASSERT_ALWAYS(a_rst_idle, !rst_n |-> !out_valid, "result valid in reset")

endmodule

bind serial_line_editor sle_port_props u_sle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .echo_action (echo_action),
    .echo_char   (echo_char),
    .erase_count (erase_count),
    .line_status (line_status),
    .line_length (line_length)
);

>>> verif/sle_checker.sv
`timescale 1ns / 1ps

module sle_checker
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] rx_byte,
    input  logic [5:0] read_index,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] echo_action,
    input  logic [7:0] echo_char,
    input  logic [6:0] erase_count,
    input  logic [1:0] line_status,
    input  logic [6:0] line_length,
    input  logic [7:0] read_byte,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        echo_action_t act;
        logic [7:0]   ch;
        logic [6:0]   erase;
        line_status_t status;
        logic [6:0]   len;
        logic [7:0]   rd;
    } line_result_t;

    // shadow copy of the editor state
    logic [7:0]   line_buf [LINE_DEPTH];
    int           typed_len;
    int           done_len;
    logic         echo_on;
    line_result_t expected_q [$];
    int           errs = 0;

    // one editing step on the shadow state
    function automatic line_result_t edit_line(input logic c, input logic [7:0] b,
                                               input logic [5:0] ix);
        line_result_t r;
        r = '0;
        r.act = ACT_NONE;
        r.status = ST_BUSY;
        if (c == CMD_READ) begin
            if (ix < done_len)
                r.rd = line_buf[ix];
        end
        else if (b == BYTE_CR || b == BYTE_LF) begin
            done_len = typed_len;
            r.status = ST_DONE;
            r.len = 7'(typed_len);
            typed_len = 0;
            if (echo_on)
                r.act = ACT_NEWLINE;
        end
        else begin
            // any other byte starts a new line, old one no longer readable
            done_len = 0;
            if (b == BYTE_CTRL_C) begin
                typed_len = 0;
                r.status = ST_CANCEL;
            end
            else if (b == BYTE_CTRL_U) begin
                if (echo_on && typed_len > 0) begin
                    r.act = ACT_ERASE;
                    r.erase = 7'(typed_len);
                end
                typed_len = 0;
            end
            else if (b == BYTE_BS || b == BYTE_DEL) begin
                if (typed_len > 0) begin
                    typed_len--;
                    if (echo_on) begin
                        r.act = ACT_ERASE;
                        r.erase = 7'd1;
                    end
                end
            end
            else if (b > BYTE_PRINT_LO && b < BYTE_DEL && typed_len < LINE_DEPTH) begin
                line_buf[typed_len] = b;
                typed_len++;
                if (echo_on) begin
                    r.act = ACT_CHAR;
                    r.ch = b;
                end
            end
            else begin
                r.act = ACT_BELL;
            end
        end
        return r;
    endfunction

    // watch config, result and input channels
    always @(posedge clk) begin : monitor
        line_result_t want;
        if (!rst_n) begin
            typed_len = 0;
            done_len = 0;
            echo_on = 1'b0;
            expected_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                echo_on = cfg_data;

            // compare the accepted result with the oldest expectation
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("sle_checker: result with no item pending: act=%0d ch=%02h erase=%0d st=%0d len=%0d rd=%02h",
                                 echo_action, echo_char, erase_count, line_status,
                                 line_length, read_byte);
                end
                else begin
                    want = expected_q.pop_front();
                    if (echo_action !== want.act || echo_char !== want.ch ||
                        erase_count !== want.erase || line_status !== want.status ||
                        line_length !== want.len || read_byte !== want.rd) begin
                        errs++;
                        if (errs <= 10)
                            $display("sle_checker: mismatch exp act=%0d ch=%02h erase=%0d st=%0d len=%0d rd=%02h got act=%0d ch=%02h erase=%0d st=%0d len=%0d rd=%02h",
                                     want.act, want.ch, want.erase, want.status, want.len,
                                     want.rd, echo_action, echo_char, erase_count,
                                     line_status, line_length, read_byte);
                    end
                end
            end

            // predict the result of the accepted item
            if (in_valid && !in_stall)
                expected_q.push_back(edit_line(cmd, rx_byte, read_index));
        end
        fail_count <= errs;
        pending <= expected_q.size();
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import sle_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       cmd;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] echo_action;
    logic [7:0] echo_char;
    logic [6:0] erase_count;
    logic [1:0] line_status;
    logic [6:0] line_length;
    logic [7:0] read_byte;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    int         fail_count;
    int         pending;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_reqs = 0;
    int          items_sent = 0;

    serial_line_editor u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .rx_byte     (rx_byte),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .echo_action (echo_action),
        .echo_char   (echo_char),
        .erase_count (erase_count),
        .line_status (line_status),
        .line_length (line_length),
        .read_byte   (read_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    sle_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .rx_byte     (rx_byte),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .echo_action (echo_action),
        .echo_char   (echo_char),
        .erase_count (erase_count),
        .line_status (line_status),
        .line_length (line_length),
        .read_byte   (read_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // result side: random stall, or a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // offer one item, with random idle cycles ahead of it
    task automatic send_item(input logic c, input logic [7:0] b, input logic [5:0] ix);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        rx_byte <= b;
        read_index <= ix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic rx(input logic [7:0] b);
        send_item(CMD_RX, b, 6'($urandom_range(63)));
    endtask

    task automatic rd(input logic [5:0] ix);
        send_item(CMD_READ, 8'($urandom_range(255)), ix);
    endtask

    // hold the sender until every result is back
    task automatic wait_drained();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (pending != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic write_echo(input logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // typed lines with edits and reads, mixed with noise items
    task automatic type_lines(input int target);
        int stop;
        int len;
        int edit_pct;
        int pick;
        bit first;
        stop = items_sent + target;
        first = 1'b1;
        while (items_sent < stop)
        begin
            if ($urandom_range(99) < 75)
            begin
                // long lines run into the full-line bell
                if (first || $urandom_range(9) == 0)
                begin
                    len = $urandom_range(60, 70);
                    edit_pct = 0;
                end
                else
                begin
                    len = $urandom_range(0, 12);
                    edit_pct = 12;
                end
                first = 1'b0;
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(99) >= edit_pct)
                    begin
                        rx(8'($urandom_range(8'h20, 8'h7E)));
                    end
                    else
                    begin
                        pick = $urandom_range(4);
                        case (pick)
                            0: rx(BYTE_BS);
                            1: rx(BYTE_DEL);
                            2: rx(BYTE_CTRL_U);
                            3: rx(8'($urandom_range(8'h00, 8'h1F)));
                            default: rx(8'($urandom_range(8'h80, 8'hFF)));
                        endcase
                    end
                end
                // line end, then reads of the finished line
                pick = $urandom_range(9);
                if (pick < 8)
                begin
                    rx($urandom_range(1) ? BYTE_CR : BYTE_LF);
                    repeat ($urandom_range(0, 4))
                    begin
                        if ($urandom_range(3) == 0)
                            rd(6'($urandom_range(63)));
                        else
                            rd(6'($urandom_range(0, (len + 1 > 63) ? 63 : len + 1)));
                    end
                end
                else if (pick == 8)
                begin
                    rx(BYTE_CTRL_C);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                              6'($urandom_range(63)));
            end
        end
    endtask

    task automatic run_phase(input logic echo, input int unsigned idle,
                             input int unsigned stall, input int count);
        wait_drained();
        write_echo(echo);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        type_lines(count);
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_RX;
        rx_byte <= 8'h00;
        read_index <= 6'd0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-line edits, byte extremes, erase, reads
        write_echo(1'b1);
        rx(BYTE_BS);
        rx(BYTE_DEL);
        rx(BYTE_CTRL_U);
        rx(BYTE_CR);
        rd(6'd0);
        rx(8'h20);
        rx(8'h7E);
        rx(BYTE_PRINT_LO);
        rx(8'h00);
        rx(8'h80);
        rx(8'hFF);
        rx(BYTE_BS);
        rx(BYTE_DEL);
        rx(8'h5A);
        rx(8'h62);
        rx(BYTE_CTRL_U);
        rx(8'h78);
        rx(8'h79);
        rx(BYTE_LF);
        rd(6'd0);
        rd(6'd1);
        rd(6'd63);
        rx(8'h71);
        rx(BYTE_CTRL_C);
        rd(6'd0);

        // no idling, then the output held off while items keep coming
        run_phase(1'b0, 0, 0, 150);
        hold_reqs++;
        repeat (30)
        begin
            if ($urandom_range(3) == 0)
                rd(6'($urandom_range(63)));
            else
                rx(8'($urandom_range(8'h20, 8'h7E)));
        end
        wait_drained();

        run_phase(1'b1, 56, 0, 200);
        run_phase(1'b0, 0, 56, 200);
        run_phase(1'b1, 35, 35, 200);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/sle_pkg.sv
hdl/sle_line_ram.sv
hdl/sle_edit_ctrl.sv
hdl/serial_line_editor.sv
hdl/sle_checker.sv
verif/sle_checker.sv
verif/tb.sv
